@@ sv/fbpa_pkg.sv @@
// Shared types, constants and codes of the fixed block pool allocator.
package fbpa_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_UNITS_DEF    = 256;
    localparam int HEADER_BYTES_DEF = 16;

    // Widths set by the register and field formats.
    localparam int ADDR_W    = 64;
    localparam int SIZE_W    = 32;
    localparam int USIZE_W   = 16;
    localparam int UNITS_W   = 9;                    // unit count register, unit index
    localparam int STRIDE_W  = USIZE_W + 1;          // unit_size plus header bytes
    localparam int SPAN_W    = UNITS_W + STRIDE_W;   // units times stride
    localparam int UNUM_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 64;
    localparam int STEP_W    = $clog2(UNITS_W + 1);
    localparam int Q_DEPTH   = 2;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_POOL_BASE    = 2'd0,
        REG_UNIT_SIZE    = 2'd1,
        REG_UNITS_IN_USE = 2'd2
    } reg_idx_t;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 2'd0,
        ST_FALLBACK = 2'd1,
        ST_RETURNED = 2'd2,
        ST_OUTSIDE  = 2'd3
    } status_t;

    // Request class decided by the front end.
    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_FALLBACK = 2'd1,
        CMD_FREE     = 2'd2,
        CMD_OUTSIDE  = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [SPAN_W-1:0]   offset;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   pool_base;
        logic [USIZE_W-1:0]  unit_size;
        logic [STRIDE_W-1:0] stride;
        logic [UNITS_W-1:0]  units;     // unit count clamped to the built maximum
        logic [SPAN_W-1:0]   span;
    } cfg_t;

    typedef struct packed {
        logic                rebuild;
        logic [UNITS_W-1:0]  units;
    } rebuild_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_ADD,
        BK_DIV,
        BK_PUSH,
        BK_DONE
    } back_state_t;

endpackage

@@ sv/fixed_block_pool_allocator.sv @@
// Top level: configuration registers, APB port and front/queue/back assembly.
//
// Fixed block pool allocator. The pool holds units_in_use units (clamped to
// MAX_UNITS) laid out from pool_base at a stride of unit_size + HEADER_BYTES
// bytes, each a header followed by its payload. Free units sit on a LIFO
// stack. An allocate request (req_type 0) whose req_size fits in unit_size
// pops the top unit and returns its payload address with status 0; an
// oversize request or an empty pool returns status 1. A free request
// (req_type 1) whose address lies strictly inside the pool pushes its unit
// back and returns status 2 with the unit number (a push onto a full stack
// is dropped, the status is the same); any other address returns status 3.
// Every request yields one result, in order. Writing any register through
// the APB port (64-bit data, registers at byte addresses 0, 8 and 16)
// rebuilds the stack so the highest unit goes out first; the rebuild takes
// effect at the write itself and needs no clearing pass, since stack entries
// that were never written since the rebuild are tracked by a low-water mark.
// Flow: a request is registered in the front stage, then two queue
// slots decouple the front from the back end. In the back end an allocate
// runs through stack pop with registered memory read, multiply of unit
// index by stride, 64-bit address add and result load; a free runs the
// 9-step restoring divider that turns the pool offset into a unit index,
// then stack push and result load. While the queue has room, requests are
// taken back to back into the front stage and queue as the back end works.
module fixed_block_pool_allocator #(
    parameter int MAX_UNITS    = fbpa_pkg::MAX_UNITS_DEF,
    parameter int HEADER_BYTES = fbpa_pkg::HEADER_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fbpa_pkg::PADDR_W-1:0]    paddr,
    input  logic [fbpa_pkg::PDATA_W-1:0]    pwdata,
    output logic [fbpa_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    // request channel
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic                            req_type,
    input  logic [fbpa_pkg::SIZE_W-1:0]     req_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]     free_addr,
    // result channel
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [fbpa_pkg::STATUS_W-1:0]   status,
    output logic [fbpa_pkg::ADDR_W-1:0]     payload_addr,
    output logic [fbpa_pkg::UNUM_W-1:0]     unit_number
);
    import fbpa_pkg::*;

    logic [ADDR_W-1:0]   pool_base_reg, pool_base_next;
    logic [USIZE_W-1:0]  unit_size_reg, unit_size_next;
    logic [UNITS_W-1:0]  units_reg, units_next;
    logic [SPAN_W-1:0]   span_reg;
    logic                wr_en;
    reg_idx_t            wr_idx;
    logic [1:0]          rd_idx;
    logic [UNITS_W-1:0]  eff_units;
    logic [UNITS_W-1:0]  eff_units_next;
    logic [STRIDE_W-1:0] stride;
    cfg_t                cfg;
    rebuild_t            rebuild;
    cmd_t                front_cmd;
    cmd_t                back_cmd;
    logic                cmd_push;
    logic                cmd_full;
    logic                cmd_pop;
    logic                cmd_valid;

    // Clamp a unit count to the built maximum.
    function automatic logic [UNITS_W-1:0] clamp_units(input logic [UNITS_W-1:0] u);
        clamp_units = (int'(u) > MAX_UNITS) ? UNITS_W'(MAX_UNITS) : u;
    endfunction

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign rd_idx = paddr[PADDR_W-1:3];
    assign wr_idx = reg_idx_t'(rd_idx);

    // Hold registers unless written; the write also triggers a rebuild.
    always_comb
    begin
        pool_base_next  = pool_base_reg;
        unit_size_next  = unit_size_reg;
        units_next      = units_reg;
        rebuild.rebuild = 1'b0;
        if (wr_en)
        begin
            case (wr_idx)
                REG_POOL_BASE:
                begin
                    pool_base_next  = pwdata;
                    rebuild.rebuild = 1'b1;
                end
                REG_UNIT_SIZE:
                begin
                    unit_size_next  = pwdata[USIZE_W-1:0];
                    rebuild.rebuild = 1'b1;
                end
                REG_UNITS_IN_USE:
                begin
                    units_next      = pwdata[UNITS_W-1:0];
                    rebuild.rebuild = 1'b1;
                end
                default:
                begin
                    rebuild.rebuild = 1'b0;
                end
            endcase
        end
        eff_units_next = clamp_units(units_next);
        rebuild.units  = eff_units_next;
    end

    always_comb
    begin
        case (rd_idx)
            REG_POOL_BASE:    prdata = pool_base_reg;
            REG_UNIT_SIZE:    prdata = {{(PDATA_W-USIZE_W){1'b0}}, unit_size_reg};
            REG_UNITS_IN_USE: prdata = {{(PDATA_W-UNITS_W){1'b0}}, units_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
            unit_size_reg <= USIZE_W'(64);
            units_reg     <= UNITS_W'(256);
        end
        else
        begin
            pool_base_reg <= pool_base_next;
            unit_size_reg <= unit_size_next;
            units_reg     <= units_next;
        end
    end

    assign eff_units = clamp_units(units_reg);
    assign stride    = {1'b0, unit_size_reg} + STRIDE_W'(HEADER_BYTES);

    // Pool span is registered from the registers, in the cycle after they change;
    // a request taken in the cycle of a write may be classified against the old span.
    always_ff @(posedge clk)
    begin
        span_reg <= SPAN_W'(eff_units) * SPAN_W'(stride);
    end

    assign cfg.pool_base = pool_base_reg;
    assign cfg.unit_size = unit_size_reg;
    assign cfg.stride    = stride;
    assign cfg.units     = eff_units;
    assign cfg.span      = span_reg;

    fbpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .req_size  (req_size),
        .free_addr (free_addr),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd),
        .cmd_full  (cmd_full)
    );

    fbpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .din       (front_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .dout      (back_cmd),
        .not_empty (cmd_valid)
    );

    fbpa_back #(
        .MAX_UNITS    (MAX_UNITS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .rebuild      (rebuild),
        .cmd          (back_cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .payload_addr (payload_addr),
        .unit_number  (unit_number)
    );

endmodule

@@ sv/fbpa_front.sv @@
// Front end: request stage and classification of allocate and free requests.
module fbpa_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fbpa_pkg::cfg_t                cfg,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          req_type,
    input  logic [fbpa_pkg::SIZE_W-1:0]   req_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]   free_addr,
    output logic                          cmd_push,
    output fbpa_pkg::cmd_t                cmd,
    input  logic                          cmd_full
);
    import fbpa_pkg::*;

    logic                stage_valid_reg;
    logic                stage_valid_next;
    logic                type_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   offset;
    logic                in_pool;
    logic                too_big;
    logic                take;

    // Offset wraps modulo 2^64; inside means strictly above the base and below the span.
    assign offset  = addr_reg - cfg.pool_base;
    assign in_pool = (offset != '0) && (offset[ADDR_W-1:SPAN_W] == '0)
                     && (offset[SPAN_W-1:0] < cfg.span);
    assign too_big = size_reg > {{(SIZE_W-USIZE_W){1'b0}}, cfg.unit_size};

    assign cmd_push  = stage_valid_reg && !cmd_full;
    assign req_ready = !stage_valid_reg || cmd_push;
    assign take      = req_valid && req_ready;

    always_comb
    begin
        cmd.offset = offset[SPAN_W-1:0];
        if (type_reg == REQ_ALLOC)
        begin
            cmd.op = too_big ? CMD_FALLBACK : CMD_ALLOC;
        end
        else
        begin
            cmd.op = in_pool ? CMD_FREE : CMD_OUTSIDE;
        end
        stage_valid_next = take ? 1'b1 : (cmd_push ? 1'b0 : stage_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            type_reg <= req_type;
            size_reg <= req_size;
            addr_reg <= free_addr;
        end
    end

endmodule

@@ sv/fbpa_queue.sv @@
// Short command queue between the front end and the back end.
module fbpa_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fbpa_pkg::cmd_t  din,
    output logic            full,
    input  logic            pop,
    output fbpa_pkg::cmd_t  dout,
    output logic            not_empty
);
    import fbpa_pkg::*;

    localparam int PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int FILL_W = $clog2(Q_DEPTH + 1);

    cmd_t               entry_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (fill_reg == FILL_W'(Q_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign dout      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ sv/fbpa_back.sv @@
// Back end: free stack, index divider, address calculation and result register.
module fbpa_back #(
    parameter int MAX_UNITS    = fbpa_pkg::MAX_UNITS_DEF,
    parameter int HEADER_BYTES = fbpa_pkg::HEADER_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fbpa_pkg::cfg_t                  cfg,
    input  fbpa_pkg::rebuild_t              rebuild,
    input  fbpa_pkg::cmd_t                  cmd,
    input  logic                            cmd_valid,
    output logic                            cmd_pop,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [fbpa_pkg::STATUS_W-1:0]   status,
    output logic [fbpa_pkg::ADDR_W-1:0]     payload_addr,
    output logic [fbpa_pkg::UNUM_W-1:0]     unit_number
);
    import fbpa_pkg::*;

    localparam int IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int CNT_W = $clog2(MAX_UNITS + 1);
    localparam int RESET_UNITS = (MAX_UNITS < 256) ? MAX_UNITS : 256;

    // Stack entries; an entry below the low mark was never written since rebuild
    // and is taken to hold its own index.
    logic [UNITS_W-1:0]  stack_mem [MAX_UNITS];

    back_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    low_reg, low_next;
    logic [SPAN_W-1:0]   rem_reg, rem_next;
    logic [SPAN_W-1:0]   div_reg, div_next;
    logic [UNITS_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                use_mem_reg, use_mem_next;
    logic [UNITS_W-1:0]  idx_reg, idx_next;
    logic [UNITS_W-1:0]  rd_data_reg;
    logic [UNITS_W-1:0]  unit_reg, unit_next;
    logic [SPAN_W-1:0]   prod_reg, prod_next;
    logic [ADDR_W-1:0]   payload_reg, payload_next;
    status_t             res_status_reg, res_status_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] status_out_reg, status_out_next;
    logic [ADDR_W-1:0]   payload_out_reg, payload_out_next;
    logic [UNUM_W-1:0]   unit_out_reg, unit_out_next;

    logic [CNT_W-1:0]    cnt_dec;
    logic [CNT_W-1:0]    eff_cnt;
    logic [UNITS_W-1:0]  unit_sel;
    logic                mem_rd;
    logic                mem_wr;

    assign cnt_dec  = count_reg - 1'b1;
    assign eff_cnt  = CNT_W'(cfg.units);
    assign unit_sel = use_mem_reg ? rd_data_reg : idx_reg;

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_out_reg;
    assign payload_addr = payload_out_reg;
    assign unit_number  = unit_out_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        low_next         = low_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        quo_next         = quo_reg;
        step_next        = step_reg;
        use_mem_next     = use_mem_reg;
        idx_next         = idx_reg;
        unit_next        = unit_reg;
        prod_next        = prod_reg;
        payload_next     = payload_reg;
        res_status_next  = res_status_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        status_out_next  = status_out_reg;
        payload_out_next = payload_out_reg;
        unit_out_next    = unit_out_reg;
        cmd_pop          = 1'b0;
        mem_rd           = 1'b0;
        mem_wr           = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    unit_next    = '0;
                    payload_next = '0;
                    case (cmd.op)
                        CMD_ALLOC:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_FALLBACK;
                                state_next      = BK_DONE;
                            end
                            else
                            begin
                                // Pop the top entry; lower the low mark with the count.
                                mem_rd       = 1'b1;
                                count_next   = cnt_dec;
                                use_mem_next = (cnt_dec >= low_reg);
                                low_next     = (cnt_dec < low_reg) ? cnt_dec : low_reg;
                                idx_next     = UNITS_W'(cnt_dec);
                                state_next   = BK_MUL;
                            end
                        end
                        CMD_FREE:
                        begin
                            rem_next   = cmd.offset;
                            div_next   = SPAN_W'(cfg.stride) << (UNITS_W - 1);
                            quo_next   = '0;
                            step_next  = STEP_W'(UNITS_W);
                            state_next = BK_DIV;
                        end
                        CMD_OUTSIDE:
                        begin
                            res_status_next = ST_OUTSIDE;
                            state_next      = BK_DONE;
                        end
                        default:
                        begin
                            res_status_next = ST_FALLBACK;
                            state_next      = BK_DONE;
                        end
                    endcase
                end
            end
            BK_MUL:
            begin
                unit_next  = unit_sel;
                prod_next  = SPAN_W'(unit_sel) * SPAN_W'(cfg.stride);
                state_next = BK_ADD;
            end
            BK_ADD:
            begin
                payload_next    = cfg.pool_base + ADDR_W'(prod_reg) + ADDR_W'(HEADER_BYTES);
                res_status_next = ST_GRANTED;
                state_next      = BK_DONE;
            end
            BK_DIV:
            begin
                // One restoring step per cycle, most significant quotient bit first.
                if (rem_reg >= div_reg)
                begin
                    rem_next = rem_reg - div_reg;
                    quo_next = {quo_reg[UNITS_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[UNITS_W-2:0], 1'b0};
                end
                div_next  = div_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = BK_PUSH;
                end
            end
            BK_PUSH:
            begin
                // Drop the push when the list already holds every unit.
                if (count_reg < eff_cnt)
                begin
                    mem_wr     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                unit_next       = quo_reg;
                payload_next    = '0;
                res_status_next = ST_RETURNED;
                state_next      = BK_DONE;
            end
            BK_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next   = 1'b1;
                    status_out_next  = res_status_reg;
                    payload_out_next = payload_reg;
                    unit_out_next    = unit_reg[UNUM_W-1:0];
                    state_next       = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (rebuild.rebuild)
        begin
            count_next = CNT_W'(rebuild.units);
            low_next   = CNT_W'(rebuild.units);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= CNT_W'(RESET_UNITS);
            low_reg       <= CNT_W'(RESET_UNITS);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            low_reg       <= low_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg         <= rem_next;
        div_reg         <= div_next;
        quo_reg         <= quo_next;
        step_reg        <= step_next;
        use_mem_reg     <= use_mem_next;
        idx_reg         <= idx_next;
        unit_reg        <= unit_next;
        prod_reg        <= prod_next;
        payload_reg     <= payload_next;
        res_status_reg  <= res_status_next;
        status_out_reg  <= status_out_next;
        payload_out_reg <= payload_out_next;
        unit_out_reg    <= unit_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            stack_mem[count_reg[IDX_W-1:0]] <= quo_reg;
        end
        if (mem_rd)
        begin
            rd_data_reg <= stack_mem[cnt_dec[IDX_W-1:0]];
        end
    end

endmodule
